@@ src/apg_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and tables for the arrowhead point generator.
// Depends on nothing; apg_vectoring, apg_rotation and the top level import it.
package apg_pkg;

	localparam int FRAC = 24;
	localparam int ITERS = 24;
	localparam int ZW = 30;
	localparam int RW = 28;
	localparam int TRIG_W = RW - 8;
	localparam int LEN_W = 10;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10);
	localparam logic [APB_ADDR_W-3:0] REG_WING_LEN = '0;

	localparam logic signed [ZW-1:0] PI_Q = ZW'(52707178);
	localparam logic signed [ZW-1:0] TWO_PI_Q = ZW'(105414356);
	localparam logic signed [ZW-1:0] HALF_PI_Q = ZW'(26353589);
	localparam logic signed [ZW-1:0] QUARTER_PI_Q = ZW'(13176795);
	localparam logic signed [RW-1:0] GAIN_Q = RW'(10188014);
	localparam logic signed [RW-1:0] ROUND_BIAS = RW'(128);

	localparam logic signed [ZW-1:0] ATAN_TAB [ITERS] = '{
		ZW'(13176795), ZW'(7778716), ZW'(4110060), ZW'(2086331),
		ZW'(1047214), ZW'(524117), ZW'(262123), ZW'(131069),
		ZW'(65536), ZW'(32768), ZW'(16384), ZW'(8192),
		ZW'(4096), ZW'(2048), ZW'(1024), ZW'(512),
		ZW'(256), ZW'(128), ZW'(64), ZW'(32),
		ZW'(16), ZW'(8), ZW'(4), ZW'(2)
	};

endpackage

@@ src/apg_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for segments in and wing points out.
// Depends on nothing.
interface apg_seg_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic signed [W-1:0] start_x;
	logic signed [W-1:0] start_y;
	logic signed [W-1:0] tip_x;
	logic signed [W-1:0] tip_y;

	modport source (output valid, output start_x, output start_y, output tip_x,
		output tip_y, input ready);
	modport sink (input valid, input start_x, input start_y, input tip_x,
		input tip_y, output ready);
endinterface

interface apg_wing_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic signed [W-1:0] left_wing_x;
	logic signed [W-1:0] left_wing_y;
	logic signed [W-1:0] right_wing_x;
	logic signed [W-1:0] right_wing_y;

	modport source (output valid, output left_wing_x, output left_wing_y,
		output right_wing_x, output right_wing_y, input ready);
	modport sink (input valid, input left_wing_x, input left_wing_y,
		input right_wing_x, input right_wing_y, output ready);
endinterface

@@ src/apg_vectoring.sv @@
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC that turns (dx, dy) into the direction angle.
// Depends on apg_pkg.
module apg_vectoring #(
	parameter int CW = 16,
	parameter int SW = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [CW:0]          dx,
	input  logic signed [CW:0]          dy,
	input  logic [SW-1:0]               side_in,
	output logic                        out_valid,
	output logic signed [apg_pkg::ZW-1:0] alpha,
	output logic [SW-1:0]               side_out
);
	import apg_pkg::*;

	localparam int XW = CW + FRAC + 4;

	logic signed [XW-1:0] x_s [ITERS+1];
	logic signed [XW-1:0] y_s [ITERS+1];
	logic signed [ZW-1:0] z_s [ITERS+1];
	logic zero_s [ITERS+1];
	logic v_s [ITERS+1];
	logic [SW-1:0] side_s [ITERS+1];

	logic signed [XW-1:0] x_in;
	logic signed [XW-1:0] y_in;
	logic neg_in;

	assign neg_in = dx[CW];
	assign x_in = XW'(dx) <<< FRAC;
	assign y_in = XW'(dy) <<< FRAC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= neg_in ? -x_in : x_in;
			y_s[0] <= neg_in ? -y_in : y_in;
			z_s[0] <= neg_in ? (dy[CW] ? -PI_Q : PI_Q) : '0;
			zero_s[0] <= (dx == '0) && (dy == '0);
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][XW-1]) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - ATAN_TAB[i];
				end
				zero_s[i+1] <= zero_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = v_s[ITERS];
	assign alpha = zero_s[ITERS] ? '0 : z_s[ITERS];
	assign side_out = side_s[ITERS];

endmodule

@@ src/apg_rotation.sv @@
`timescale 1ns / 1ps
// Two-lane pipelined rotation CORDIC giving cosine and sine of two angles.
// Depends on apg_pkg.
module apg_rotation #(
	parameter int SW = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic signed [apg_pkg::ZW-1:0]     angle [2],
	input  logic [SW-1:0]                   side_in,
	output logic                            out_valid,
	output logic signed [apg_pkg::TRIG_W-1:0] cos_v [2],
	output logic signed [apg_pkg::TRIG_W-1:0] sin_v [2],
	output logic [SW-1:0]                   side_out
);
	import apg_pkg::*;

	logic v_w;
	logic v_s [ITERS+1];
	logic v_r;
	logic [SW-1:0] side_w;
	logic [SW-1:0] side_s [ITERS+1];
	logic [SW-1:0] side_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_w <= 1'b0;
			v_s[0] <= 1'b0;
			v_r <= 1'b0;
		end else if (en) begin
			v_w <= in_valid;
			v_s[0] <= v_w;
			v_r <= v_s[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_w <= side_in;
			side_s[0] <= side_w;
			side_r <= side_s[ITERS];
		end
	end

	for (genvar i = 0; i < ITERS; i++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [ZW-1:0] t_w;
		logic signed [RW-1:0] x_s [ITERS+1];
		logic signed [RW-1:0] y_s [ITERS+1];
		logic signed [ZW-1:0] t_s [ITERS+1];
		logic neg_s [ITERS+1];
		logic signed [RW-1:0] x_fix;
		logic signed [RW-1:0] y_fix;
		logic signed [RW-1:0] x_rnd;
		logic signed [RW-1:0] y_rnd;
		logic signed [TRIG_W-1:0] cos_r;
		logic signed [TRIG_W-1:0] sin_r;

		always_ff @(posedge clk) begin
			if (en) begin
				if (angle[l] > PI_Q) begin
					t_w <= angle[l] - TWO_PI_Q;
				end else if (angle[l] <= -PI_Q) begin
					t_w <= angle[l] + TWO_PI_Q;
				end else begin
					t_w <= angle[l];
				end

				x_s[0] <= GAIN_Q;
				y_s[0] <= '0;
				if (t_w > HALF_PI_Q) begin
					t_s[0] <= t_w - PI_Q;
					neg_s[0] <= 1'b1;
				end else if (t_w < -HALF_PI_Q) begin
					t_s[0] <= t_w + PI_Q;
					neg_s[0] <= 1'b1;
				end else begin
					t_s[0] <= t_w;
					neg_s[0] <= 1'b0;
				end
			end
		end

		for (genvar i = 0; i < ITERS; i++) begin : g_iter
			logic signed [RW-1:0] xs;
			logic signed [RW-1:0] ys;

			assign xs = x_s[i] >>> i;
			assign ys = y_s[i] >>> i;

			always_ff @(posedge clk) begin
				if (en) begin
					if (!t_s[i][ZW-1]) begin
						x_s[i+1] <= x_s[i] - ys;
						y_s[i+1] <= y_s[i] + xs;
						t_s[i+1] <= t_s[i] - ATAN_TAB[i];
					end else begin
						x_s[i+1] <= x_s[i] + ys;
						y_s[i+1] <= y_s[i] - xs;
						t_s[i+1] <= t_s[i] + ATAN_TAB[i];
					end
					neg_s[i+1] <= neg_s[i];
				end
			end
		end

		assign x_fix = neg_s[ITERS] ? -x_s[ITERS] : x_s[ITERS];
		assign y_fix = neg_s[ITERS] ? -y_s[ITERS] : y_s[ITERS];
		assign x_rnd = x_fix + ROUND_BIAS;
		assign y_rnd = y_fix + ROUND_BIAS;

		always_ff @(posedge clk) begin
			if (en) begin
				cos_r <= x_rnd[RW-1:8];
				sin_r <= y_rnd[RW-1:8];
			end
		end

		assign cos_v[l] = cos_r;
		assign sin_v[l] = sin_r;
	end

	assign out_valid = v_r;
	assign side_out = side_r;

endmodule

@@ src/arrowhead_point_generator_top.sv @@
`timescale 1ns / 1ps
// Top level of the arrowhead point generator: input differences, wing angles,
// scaling, saturation, output register and APB register. Uses apg_pkg,
// apg_if, apg_vectoring and apg_rotation.
//
// Usage: each transaction on the seg channel carries one line segment (start
// point and tip). For each one the block returns exactly one transaction on
// the wing channel with the left and right arrowhead wing points, in order.
// Both channels use valid/ready; a transaction moves when both are high.
// The wing length is the register at APB byte address 0 (reset
// value 10); write it only while no segment is in flight.
// Throughput: one segment per clock cycle, sustained while wing.ready stays high.
// The work is a fully pipelined datapath of a 24-stage vectoring CORDIC followed
// by two 24-stage rotation CORDICs working side by side, plus setup, scaling and
// output stages. A segment goes through the difference register, vectoring CORDIC,
// wing angle register, rotation CORDIC, product, saturation and output registers.
// Reset: arst_n clears all valid bits and sets the wing length to 10; the block
// is ready for segments as soon as reset is released.
// Stall: while the receiver holds ready low, a result waits in the output
// register and the pipeline still moves on until its last stage is full; only
// then does seg.ready fall. Nothing is lost or repeated.
module arrowhead_point_generator_top #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	apg_seg_if.sink                        seg,
	apg_wing_if.source                     wing,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [apg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [apg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [apg_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import apg_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int SW = 2 * CW;
	localparam int PW = LEN_W + 1 + TRIG_W;
	localparam int OFF_W = PW - 16;
	localparam int SUMW = (CW > OFF_W ? CW : OFF_W) + 1;
	localparam logic signed [SUMW-1:0] MAXV = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SUMW-1:0] MINV = {{(SUMW-CW+1){1'b1}}, {(CW-1){1'b0}}};
	localparam logic signed [PW-1:0] TRUNC_BIAS = PW'(65535);

	logic [LEN_W-1:0] wing_len_q;
	logic reg_hit;

	assign pready = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_WING_LEN);
	assign prdata = reg_hit ? APB_DATA_W'(wing_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wing_len_q <= LEN_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			wing_len_q <= pwdata[LEN_W-1:0];
		end
	end

	logic adv;
	logic load;
	logic out_v_q;
	logic signed [CW-1:0] wing_q [4];

	logic v_s1;
	logic signed [CW:0] dx_s1;
	logic signed [CW:0] dy_s1;
	logic signed [CW-1:0] tip_x_s1;
	logic signed [CW-1:0] tip_y_s1;

	logic vec_valid;
	logic signed [ZW-1:0] alpha;
	logic [SW-1:0] vec_side;

	logic v_s2;
	logic signed [ZW-1:0] beta_s2 [2];
	logic [SW-1:0] side_s2;

	logic rot_valid;
	logic signed [TRIG_W-1:0] cos_v [2];
	logic signed [TRIG_W-1:0] sin_v [2];
	logic [SW-1:0] rot_side;

	logic signed [TRIG_W-1:0] trig_v [4];
	logic signed [CW-1:0] tip_v [4];
	logic signed [LEN_W:0] len_ext;

	logic v_s3;
	logic signed [PW-1:0] prod_s3 [4];
	logic signed [CW-1:0] tip_s3 [4];

	logic v_s4;
	logic signed [CW-1:0] wing_s4 [4];

	assign load = !out_v_q || wing.ready;
	assign adv = !v_s4 || load;
	assign seg.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= seg.valid;
				v_s2 <= vec_valid;
				v_s3 <= rot_valid;
				v_s4 <= v_s3;
			end
			if (load) begin
				out_v_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= (CW+1)'(seg.tip_x) - (CW+1)'(seg.start_x);
			dy_s1 <= (CW+1)'(seg.tip_y) - (CW+1)'(seg.start_y);
			tip_x_s1 <= seg.tip_x;
			tip_y_s1 <= seg.tip_y;
			beta_s2[0] <= alpha + PI_Q - QUARTER_PI_Q;
			beta_s2[1] <= alpha + PI_Q + QUARTER_PI_Q;
			side_s2 <= vec_side;
		end
	end

	apg_vectoring #(
		.CW(CW),
		.SW(SW)
	) u_vec (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s1),
		.dx(dx_s1),
		.dy(dy_s1),
		.side_in({tip_x_s1, tip_y_s1}),
		.out_valid(vec_valid),
		.alpha(alpha),
		.side_out(vec_side)
	);

	apg_rotation #(
		.SW(SW)
	) u_rot (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s2),
		.angle(beta_s2),
		.side_in(side_s2),
		.out_valid(rot_valid),
		.cos_v(cos_v),
		.sin_v(sin_v),
		.side_out(rot_side)
	);

	assign trig_v[0] = cos_v[0];
	assign trig_v[1] = sin_v[0];
	assign trig_v[2] = cos_v[1];
	assign trig_v[3] = sin_v[1];
	assign tip_v[0] = rot_side[SW-1:CW];
	assign tip_v[1] = rot_side[CW-1:0];
	assign tip_v[2] = rot_side[SW-1:CW];
	assign tip_v[3] = rot_side[CW-1:0];
	assign len_ext = {1'b0, wing_len_q};

	for (genvar k = 0; k < 4; k++) begin : g_out
		logic signed [PW-1:0] prod_adj;
		logic signed [OFF_W-1:0] off;
		logic signed [SUMW-1:0] sum;

		assign prod_adj = prod_s3[k] + (prod_s3[k][PW-1] ? TRUNC_BIAS : '0);
		assign off = prod_adj[PW-1:16];
		assign sum = SUMW'(tip_s3[k]) + SUMW'(off);

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s3[k] <= PW'(len_ext) * PW'(trig_v[k]);
				tip_s3[k] <= tip_v[k];
				if (sum > MAXV) begin
					wing_s4[k] <= MAXV[CW-1:0];
				end else if (sum < MINV) begin
					wing_s4[k] <= MINV[CW-1:0];
				end else begin
					wing_s4[k] <= sum[CW-1:0];
				end
			end
			if (load) begin
				wing_q[k] <= wing_s4[k];
			end
		end
	end

	assign wing.valid = out_v_q;
	assign wing.left_wing_x = wing_q[0];
	assign wing.left_wing_y = wing_q[1];
	assign wing.right_wing_x = wing_q[2];
	assign wing.right_wing_y = wing_q[3];

endmodule
